// File: rtl/smx_pkg.sv
package smx_pkg;

    // width of the running vertex index
    localparam int INDEX_BITS = 32;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 48;

    typedef logic signed [31:0] coord_t;
    typedef logic signed [63:0] wide_t;
    typedef logic signed [31:0] unit_t;
    typedef logic signed [15:0] normal_t;
    typedef logic [47:0]        color_t;
    typedef logic [39:0]        dist_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BEAD_WIDTH   = CFG_IDX_W'(0),
        CFG_BEAD_HEIGHT  = CFG_IDX_W'(1),
        CFG_PRINT_COLOR  = CFG_IDX_W'(2),
        CFG_TRAVEL_COLOR = CFG_IDX_W'(3)
    } cfg_idx_t;

    // operands for the shared multiplier
    typedef struct packed {
        unit_t a;
        unit_t b;
    } mul_req_t;

    // normalizer status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
        logic nonzero;
    } norm_stat_t;

    typedef enum logic [2:0] {
        N_IDLE,
        N_SHR,
        N_SHL,
        N_SQ,
        N_SQRT,
        N_DLOAD,
        N_DIV,
        N_DONE
    } norm_state_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FWD_S,
        S_FWD_W,
        S_RT,
        S_RT_S,
        S_RT_W,
        S_CR,
        S_UP_S,
        S_UP_W,
        S_AB,
        S_NUM,
        S_OFF,
        S_NRM_S,
        S_NRM_W,
        S_EMIT
    } seq_state_t;

endpackage

// File: rtl/smx_seg_if.sv
interface smx_seg_if;
    import smx_pkg::*;

    logic   valid;
    logic   ready;
    coord_t start_x;
    coord_t start_y;
    coord_t start_z;
    coord_t end_x;
    coord_t end_y;
    coord_t end_z;
    logic   is_print;
    dist_t  path_distance;

    modport source (
        output valid, start_x, start_y, start_z, end_x, end_y, end_z, is_print,
               path_distance,
        input  ready
    );

    modport sink (
        input  valid, start_x, start_y, start_z, end_x, end_y, end_z, is_print,
               path_distance,
        output ready
    );

endinterface

// File: rtl/smx_vtx_if.sv
interface smx_vtx_if;
    import smx_pkg::*;

    logic        valid;
    logic        ready;
    coord_t      vertex_x;
    coord_t      vertex_y;
    coord_t      vertex_z;
    normal_t     normal_x;
    normal_t     normal_y;
    normal_t     normal_z;
    color_t      vertex_color;
    dist_t       reveal_at;
    logic [31:0] vertex_number;
    logic        last;

    modport source (
        output valid, vertex_x, vertex_y, vertex_z, normal_x, normal_y, normal_z,
               vertex_color, reveal_at, vertex_number, last,
        input  ready
    );

    modport sink (
        input  valid, vertex_x, vertex_y, vertex_z, normal_x, normal_y, normal_z,
               vertex_color, reveal_at, vertex_number, last,
        output ready
    );

endinterface

// File: rtl/smx_cfg_if.sv
interface smx_cfg_if;
    import smx_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );

    modport sink (
        input  valid, index, data,
        output ready
    );

endinterface

// File: rtl/smx_mul.sv
module smx_mul (
    input  logic              clk,
    input  smx_pkg::mul_req_t req,
    output smx_pkg::wide_t    p
);
    import smx_pkg::*;

    wide_t p_reg;

    // signed 32x32, one register stage
    always_ff @(posedge clk)
    begin
        p_reg <= req.a * req.b;
    end

    assign p = p_reg;

endmodule

// File: rtl/smx_norm.sv
module smx_norm (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  smx_pkg::wide_t      vec_in [3],
    input  smx_pkg::wide_t      mul_p,
    output smx_pkg::mul_req_t   mul_req,
    output smx_pkg::unit_t      u [3],
    output smx_pkg::norm_stat_t stat
);
    import smx_pkg::*;

    norm_state_t state_reg, state_next;
    logic [4:0]  cnt_reg;
    logic [1:0]  ci_reg;

    logic [63:0] m_reg [3];
    logic [63:0] mx_reg;
    logic [2:0]  sgn_reg;
    logic [63:0] acc_reg;
    logic [63:0] res_reg;
    logic [63:0] bit_reg;
    logic [31:0] rem_reg;
    logic [31:0] dq_reg;
    unit_t       u_reg [3];
    logic        nz_reg;

    logic [63:0] mag_in [3];
    logic [63:0] mx_in;
    logic [63:0] rb;
    logic        sq_ge;
    logic [63:0] dvd;
    logic [32:0] t;
    logic        dv_ge;
    logic [31:0] q_next;
    logic [1:0]  sq_idx;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag_in[i] = vec_in[i][63] ? (~vec_in[i] + 64'd1) : vec_in[i];
        end
        mx_in = (mag_in[0] > mag_in[1]) ? mag_in[0] : mag_in[1];
        if (mag_in[2] > mx_in)
        begin
            mx_in = mag_in[2];
        end
    end

    // square root step
    assign rb    = res_reg + bit_reg;
    assign sq_ge = acc_reg >= rb;

    // restoring divide step, divisor is the root
    assign dvd    = {4'd0, m_reg[ci_reg][29:0], 30'd0} + 64'(res_reg[31:1]);
    assign t      = {rem_reg, dq_reg[31]};
    assign dv_ge  = t >= {1'b0, res_reg[31:0]};
    assign q_next = {dq_reg[30:0], dv_ge};

    assign sq_idx = (cnt_reg < 5'd3) ? cnt_reg[1:0] : 2'd0;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            N_IDLE:  if (start) state_next = (mx_in == 64'd0) ? N_DONE : N_SHR;
            N_SHR:   if (mx_reg[63:30] == '0) state_next = N_SHL;
            N_SHL:   if (mx_reg[63:29] != '0) state_next = N_SQ;
            N_SQ:    if (cnt_reg == 5'd3) state_next = N_SQRT;
            N_SQRT:  if (cnt_reg == 5'd31) state_next = N_DLOAD;
            N_DLOAD: state_next = N_DIV;
            N_DIV:
            begin
                if (cnt_reg == 5'd31)
                begin
                    state_next = (ci_reg == 2'd2) ? N_DONE : N_DLOAD;
                end
            end
            N_DONE:  state_next = N_IDLE;
            default: state_next = N_IDLE;
        endcase
    end

    always_comb
    begin
        mul_req.a    = unit_t'({2'b00, m_reg[sq_idx][29:0]});
        mul_req.b    = unit_t'({2'b00, m_reg[sq_idx][29:0]});
        stat.busy    = state_reg != N_IDLE;
        stat.done    = state_reg == N_DONE;
        stat.nonzero = nz_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
            cnt_reg   <= '0;
            ci_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= (state_next != state_reg) ? 5'd0 : cnt_reg + 5'd1;
            if (state_reg == N_IDLE)
            begin
                ci_reg <= '0;
            end
            else if (state_reg == N_DIV && cnt_reg == 5'd31)
            begin
                ci_reg <= ci_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            N_IDLE:
            begin
                if (start)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        m_reg[i]   <= mag_in[i];
                        sgn_reg[i] <= vec_in[i][63];
                        u_reg[i]   <= '0;
                    end
                    mx_reg <= mx_in;
                    nz_reg <= mx_in != 64'd0;
                end
            end
            N_SHR:
            begin
                if (mx_reg[63:30] != '0)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        m_reg[i] <= m_reg[i] >> 1;
                    end
                    mx_reg <= mx_reg >> 1;
                end
            end
            N_SHL:
            begin
                if (mx_reg[63:29] == '0)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        m_reg[i] <= m_reg[i] << 1;
                    end
                    mx_reg <= mx_reg << 1;
                end
            end
            N_SQ:
            begin
                // products come back in the cycle after issue
                acc_reg <= (cnt_reg == 5'd0) ? 64'd0 : acc_reg + 64'(mul_p);
                res_reg <= '0;
                bit_reg <= 64'd1 << 62;
            end
            N_SQRT:
            begin
                if (sq_ge)
                begin
                    acc_reg <= acc_reg - rb;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            N_DLOAD:
            begin
                rem_reg <= dvd[63:32];
                dq_reg  <= dvd[31:0];
            end
            N_DIV:
            begin
                rem_reg <= dv_ge ? 32'(t - {1'b0, res_reg[31:0]}) : t[31:0];
                dq_reg  <= q_next;
                if (cnt_reg == 5'd31)
                begin
                    u_reg[ci_reg] <= sgn_reg[ci_reg] ? -unit_t'(q_next) : unit_t'(q_next);
                end
            end
            N_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    assign u = u_reg;

endmodule

// File: rtl/segment_prism_mesh_expander.sv
// segment accept to first vertex: six or seven passes through the shared
//   normalizer (bit-serial root and divide), six for a vertical move
// throughput: one segment at a time, then eight vertices at one per cycle
//   when the sink is ready; a zero-length segment is dropped
// reset: vertex counter cleared, bead sizes at 26214 and 13107, colors zero
module segment_prism_mesh_expander (
    input  logic      clk,
    input  logic      rst_n,
    smx_seg_if.sink   seg,
    smx_vtx_if.source vtx,
    smx_cfg_if.sink   cfg
);
    import smx_pkg::*;

    typedef logic signed [25:0] off_t;

    localparam unit_t       ONE_Q30  = 32'sh4000_0000;
    // half of 40 in Q30, rounding term of the offset divide
    localparam logic [63:0] HALF_DIV = 64'd20 << 30;
    // ceil(2^27 / 5), exact for the offset quotient range
    localparam unit_t       DIV5_MUL = 32'sd26843546;

    // configuration registers
    logic [19:0]        bead_w_reg;
    logic [19:0]        bead_h_reg;
    color_t             print_color_reg;
    color_t             travel_color_reg;

    // sequencer
    seq_state_t         state_reg, state_next;
    logic [2:0]         cnt_reg;
    logic [1:0]         k_reg;
    logic [2:0]         vi_reg;
    logic [INDEX_BITS-1:0] vcount_reg;

    // per-segment working set
    coord_t             p0_reg [3];
    coord_t             p1_reg [3];
    color_t             color_reg;
    dist_t              reveal_reg;
    logic [24:0]        hw_reg;
    logic [24:0]        hh_reg;
    unit_t              fw_reg [3];
    unit_t              rt_reg [3];
    unit_t              up_reg [3];
    wide_t              nv_reg [3];
    wide_t              ab_reg [6];
    off_t               off_reg [4][3];
    normal_t            nrm_reg [4][3];

    // shared units
    mul_req_t           top_req;
    mul_req_t           norm_req;
    mul_req_t           mreq;
    wide_t              mul_p;
    logic               norm_start;
    unit_t              nu [3];
    norm_stat_t         nstat;

    logic [24:0]        s_val [3];
    logic               rneg;
    logic               uneg;
    logic               off_neg;
    logic [25:0]        off_q;
    logic               vert;
    logic [1:0]         vk;

    function automatic coord_t sat_add(input coord_t base, input off_t off);
        logic signed [33:0] s;
        s = $signed({{2{base[31]}}, base}) + $signed({{8{off[25]}}, off});
        if (s > 34'sd2147483647)
        begin
            return 32'sh7fff_ffff;
        end
        else if (s < -34'sd2147483648)
        begin
            return 32'sh8000_0000;
        end
        return coord_t'(s[31:0]);
    endfunction

    // Q1.30 to Q1.14, half away from zero
    function automatic normal_t round_q14(input unit_t n);
        logic [31:0] m;
        logic [31:0] r;
        m = n[31] ? (~n + 32'd1) : n;
        r = (m + 32'd32768) >> 16;
        return n[31] ? -normal_t'(r[15:0]) : normal_t'(r[15:0]);
    endfunction

    smx_mul u_mul (
        .clk (clk),
        .req (mreq),
        .p   (mul_p)
    );

    smx_norm u_norm (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (norm_start),
        .vec_in  (nv_reg),
        .mul_p   (mul_p),
        .mul_req (norm_req),
        .u       (nu),
        .stat    (nstat)
    );

    // the normalizer owns the multiplier while it runs
    assign mreq = nstat.busy ? norm_req : top_req;

    // offset quotient prescale: (|num| + 20*2^30) >> 33, the /5 is done by multiply
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            s_val[c] = 25'(((nv_reg[c][63] ? (~nv_reg[c] + 64'd1) : nv_reg[c]) + HALF_DIV)
                           >> 33);
        end
    end

    // corner order (-r,-u), (+r,-u), (+r,+u), (-r,+u)
    assign rneg = ~(k_reg[0] ^ k_reg[1]);
    assign uneg = ~k_reg[1];
    assign vert = (fw_reg[0] == '0) && (fw_reg[1] == '0);
    assign off_q = mul_p[52:27];

    always_comb
    begin
        unique case (cnt_reg)
            3'd1:    off_neg = nv_reg[0][63];
            3'd2:    off_neg = nv_reg[1][63];
            3'd3:    off_neg = nv_reg[2][63];
            default: off_neg = 1'b0;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (seg.valid) state_next = S_FWD_S;
            S_FWD_S: state_next = S_FWD_W;
            S_FWD_W: if (nstat.done) state_next = nstat.nonzero ? S_RT : S_IDLE;
            S_RT:    state_next = vert ? S_CR : S_RT_S;
            S_RT_S:  state_next = S_RT_W;
            S_RT_W:  if (nstat.done) state_next = S_CR;
            S_CR:    if (cnt_reg == 3'd4) state_next = S_UP_S;
            S_UP_S:  state_next = S_UP_W;
            S_UP_W:  if (nstat.done) state_next = S_AB;
            S_AB:    if (cnt_reg == 3'd6) state_next = S_NUM;
            S_NUM:   state_next = S_OFF;
            S_OFF:   if (cnt_reg == 3'd3) state_next = S_NRM_S;
            S_NRM_S: state_next = S_NRM_W;
            S_NRM_W:
            begin
                if (nstat.done)
                begin
                    state_next = (k_reg == 2'd3) ? S_EMIT : S_NUM;
                end
            end
            S_EMIT:  if (vtx.ready && vi_reg == 3'd7) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // control outputs and multiplier operands
    always_comb
    begin
        seg.ready  = state_reg == S_IDLE;
        vtx.valid  = state_reg == S_EMIT;
        cfg.ready  = 1'b1;
        norm_start = (state_reg == S_FWD_S) || (state_reg == S_RT_S) ||
                     (state_reg == S_UP_S)  || (state_reg == S_NRM_S);
        top_req    = '0;
        unique case (state_reg)
            S_CR:
            begin
                // rt z is always zero, so only four cross terms
                unique case (cnt_reg)
                    3'd0:    begin top_req.a = rt_reg[1]; top_req.b = fw_reg[2]; end
                    3'd1:    begin top_req.a = rt_reg[0]; top_req.b = fw_reg[2]; end
                    3'd2:    begin top_req.a = rt_reg[0]; top_req.b = fw_reg[1]; end
                    3'd3:    begin top_req.a = rt_reg[1]; top_req.b = fw_reg[0]; end
                    default: top_req = '0;
                endcase
            end
            S_AB:
            begin
                unique case (cnt_reg)
                    3'd0:    begin top_req.a = rt_reg[0]; top_req.b = unit_t'({7'd0, hw_reg}); end
                    3'd1:    begin top_req.a = rt_reg[1]; top_req.b = unit_t'({7'd0, hw_reg}); end
                    3'd2:    begin top_req.a = rt_reg[2]; top_req.b = unit_t'({7'd0, hw_reg}); end
                    3'd3:    begin top_req.a = up_reg[0]; top_req.b = unit_t'({7'd0, hh_reg}); end
                    3'd4:    begin top_req.a = up_reg[1]; top_req.b = unit_t'({7'd0, hh_reg}); end
                    3'd5:    begin top_req.a = up_reg[2]; top_req.b = unit_t'({7'd0, hh_reg}); end
                    default: top_req = '0;
                endcase
            end
            S_OFF:
            begin
                unique case (cnt_reg)
                    3'd0:    begin top_req.a = unit_t'({7'd0, s_val[0]}); top_req.b = DIV5_MUL; end
                    3'd1:    begin top_req.a = unit_t'({7'd0, s_val[1]}); top_req.b = DIV5_MUL; end
                    3'd2:    begin top_req.a = unit_t'({7'd0, s_val[2]}); top_req.b = DIV5_MUL; end
                    default: top_req = '0;
                endcase
            end
            default: top_req = '0;
        endcase
    end

    // control state and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            cnt_reg          <= '0;
            k_reg            <= '0;
            vi_reg           <= '0;
            vcount_reg       <= '0;
            bead_w_reg       <= 20'd26214;
            bead_h_reg       <= 20'd13107;
            print_color_reg  <= '0;
            travel_color_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= (state_next != state_reg) ? 3'd0 : cnt_reg + 3'd1;

            if (state_reg == S_IDLE)
            begin
                k_reg  <= '0;
                vi_reg <= '0;
            end
            else if (state_reg == S_NRM_W && nstat.done)
            begin
                k_reg <= k_reg + 2'd1;
            end

            // one vertex leaves per item handshake
            if (state_reg == S_EMIT && vtx.ready)
            begin
                vi_reg     <= vi_reg + 3'd1;
                vcount_reg <= vcount_reg + 1'b1;
            end

            if (cfg.valid)
            begin
                unique case (cfg.index)
                    CFG_BEAD_WIDTH:   bead_w_reg       <= cfg.data[19:0];
                    CFG_BEAD_HEIGHT:  bead_h_reg       <= cfg.data[19:0];
                    CFG_PRINT_COLOR:  print_color_reg  <= cfg.data[47:0];
                    CFG_TRAVEL_COLOR: travel_color_reg <= cfg.data[47:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // segment datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (seg.valid)
                begin
                    p0_reg[0]  <= seg.start_x;
                    p0_reg[1]  <= seg.start_y;
                    p0_reg[2]  <= seg.start_z;
                    p1_reg[0]  <= seg.end_x;
                    p1_reg[1]  <= seg.end_y;
                    p1_reg[2]  <= seg.end_z;
                    nv_reg[0]  <= wide_t'(seg.end_x) - wide_t'(seg.start_x);
                    nv_reg[1]  <= wide_t'(seg.end_y) - wide_t'(seg.start_y);
                    nv_reg[2]  <= wide_t'(seg.end_z) - wide_t'(seg.start_z);
                    color_reg  <= seg.is_print ? print_color_reg : travel_color_reg;
                    reveal_reg <= seg.path_distance;
                    // half extents times 40: x20 for print, x3 for travel
                    hw_reg <= seg.is_print ?
                              (25'(bead_w_reg) << 4) + (25'(bead_w_reg) << 2) :
                              (25'(bead_w_reg) << 1) + 25'(bead_w_reg);
                    hh_reg <= seg.is_print ?
                              (25'(bead_h_reg) << 4) + (25'(bead_h_reg) << 2) :
                              (25'(bead_h_reg) << 1) + 25'(bead_h_reg);
                end
            end
            S_FWD_W:
            begin
                if (nstat.done)
                begin
                    fw_reg <= nu;
                end
            end
            S_RT:
            begin
                // vertical move: right falls back to +x
                if (vert)
                begin
                    rt_reg[0] <= ONE_Q30;
                    rt_reg[1] <= '0;
                    rt_reg[2] <= '0;
                end
                else
                begin
                    nv_reg[0] <= wide_t'(fw_reg[1]);
                    nv_reg[1] <= -wide_t'(fw_reg[0]);
                    nv_reg[2] <= '0;
                end
            end
            S_RT_W:
            begin
                if (nstat.done)
                begin
                    rt_reg <= nu;
                end
            end
            S_CR:
            begin
                // up = right x forward
                unique case (cnt_reg)
                    3'd1:    nv_reg[0] <= mul_p;
                    3'd2:    nv_reg[1] <= -mul_p;
                    3'd3:    nv_reg[2] <= mul_p;
                    3'd4:    nv_reg[2] <= nv_reg[2] - mul_p;
                    default:
                    begin
                    end
                endcase
            end
            S_UP_W:
            begin
                if (nstat.done)
                begin
                    up_reg <= nu;
                end
            end
            S_AB:
            begin
                if (cnt_reg != 3'd0)
                begin
                    ab_reg[cnt_reg - 3'd1] <= mul_p;
                end
            end
            S_NUM:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    nv_reg[c] <= (rneg ? -ab_reg[c] : ab_reg[c]) +
                                 (uneg ? -ab_reg[c + 3] : ab_reg[c + 3]);
                end
            end
            S_OFF:
            begin
                if (cnt_reg != 3'd0)
                begin
                    off_reg[k_reg][2'(cnt_reg - 3'd1)] <= off_neg ? -off_t'(off_q)
                                                                   : off_t'(off_q);
                end
            end
            S_NRM_W:
            begin
                // zero offset takes right as its normal
                if (nstat.done)
                begin
                    for (int c = 0; c < 3; c++)
                    begin
                        nrm_reg[k_reg][c] <= round_q14(nstat.nonzero ? nu[c] : rt_reg[c]);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // vertex output, start corners first then end corners
    assign vk = vi_reg[1:0];

    always_comb
    begin
        vtx.vertex_x      = sat_add(vi_reg[2] ? p1_reg[0] : p0_reg[0], off_reg[vk][0]);
        vtx.vertex_y      = sat_add(vi_reg[2] ? p1_reg[1] : p0_reg[1], off_reg[vk][1]);
        vtx.vertex_z      = sat_add(vi_reg[2] ? p1_reg[2] : p0_reg[2], off_reg[vk][2]);
        vtx.normal_x      = nrm_reg[vk][0];
        vtx.normal_y      = nrm_reg[vk][1];
        vtx.normal_z      = nrm_reg[vk][2];
        vtx.vertex_color  = color_reg;
        vtx.reveal_at     = reveal_reg;
        vtx.vertex_number = 32'(vcount_reg);
        vtx.last          = vi_reg == 3'd7;
    end

endmodule
